>>> rtl/tec_pkg.sv
package tec_pkg;

  // fixed-point formats
  localparam int STRAIN_FRAC = 30;
  localparam int DIR_FRAC    = 30;
  localparam int OUT_FRAC    = 16;
  localparam int NUM_SHIFT   = STRAIN_FRAC - OUT_FRAC;

  // field widths
  localparam int EA_W    = 40;
  localparam int COORD_W = 32;
  localparam int OUT_W   = 64;
  localparam int LEN_W   = 36;
  localparam int DIR_W   = DIR_FRAC + 1;
  localparam int MAG_W   = 68;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_AXIAL_RIGIDITY   = 2'd0;
  localparam cfg_idx_t CFG_THERMAL_STRAIN   = 2'd1;
  localparam cfg_idx_t CFG_GEOMETRIC_ENABLE = 2'd2;
  localparam cfg_idx_t CFG_MIN_LENGTH       = 2'd3;

  typedef logic signed [OUT_W-1:0] q47_t;

  localparam q47_t Q_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam q47_t Q_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [MAG_W-1:0] LIM_NEG = MAG_W'(1) << (OUT_W-1);
  localparam logic [MAG_W-1:0] LIM_POS = LIM_NEG - MAG_W'(1);

  // row and column of the six distinct tangent entries
  localparam int PAIR_I [6] = '{0, 1, 2, 0, 0, 1};
  localparam int PAIR_J [6] = '{0, 1, 2, 1, 2, 2};

  function automatic int wmax(int a, int b);
    return (a > b) ? a : b;
  endfunction

  // saturate a sign and magnitude pair to signed 64 bits
  function automatic q47_t sat_mag(logic [MAG_W-1:0] m, logic neg);
    q47_t r;
    if (neg) begin
      r = (m > LIM_NEG) ? Q_MIN : q47_t'(64'd0 - m[OUT_W-1:0]);
    end else begin
      r = (m > LIM_POS) ? Q_MAX : q47_t'(m[OUT_W-1:0]);
    end
    return r;
  endfunction

  // saturate a signed 69-bit value to signed 64 bits
  function automatic q47_t sat_s(logic signed [68:0] x);
    q47_t r;
    if (x[68:63] == {6{x[68]}}) begin
      r = q47_t'(x[63:0]);
    end else begin
      r = x[68] ? Q_MIN : Q_MAX;
    end
    return r;
  endfunction

endpackage

>>> rtl/tec_delay.sv
module tec_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [DEPTH];

  // shift line, advances with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule

>>> rtl/tec_sqrt.sv
module tec_sqrt #(
  parameter int WI = 72
) (
  input  logic            clk,
  input  logic            en,
  input  logic [WI-1:0]   rad,
  output logic [WI/2-1:0] root
);

  localparam int WO = WI / 2;
  localparam int WR = WO + 2;

  logic [WR-1:0] rem_r  [WO];
  logic [WO-1:0] root_r [WO];
  logic [WI-1:0] src_r  [WO];

  // one result bit per stage, restoring digit recurrence
  for (genvar k = 0; k < WO; k++) begin : g_stage
    logic [WR-1:0] rem_in;
    logic [WO-1:0] root_in;
    logic [WI-1:0] src_in;
    logic [WR+1:0] acc;
    logic [WR+1:0] trial;
    logic [WR+1:0] diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign src_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign src_in  = src_r[k-1];
    end

    assign acc   = {rem_in, src_in[WI-1 -: 2]};
    assign trial = (WR+2)'({root_in, 2'b01});
    assign ge    = acc >= trial;
    assign diff  = acc - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_in[WO-2:0], ge};
      end
    end

    if (k < WO - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[WR-1:0] : acc[WR-1:0];
          src_r[k] <= src_in << 2;
        end
      end
    end
  end

  assign root = root_r[WO-1];

endmodule

>>> rtl/tec_div.sv
module tec_div
  import tec_pkg::*;
#(
  parameter int WN = 64,
  parameter int WD = 36,
  parameter int WQ = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [WN-1:0] dividend,
  input  logic [WD-1:0] divisor,
  output logic [WQ-1:0] quo,
  output logic          ovf
);

  localparam int WH = WN - WQ;
  localparam int WR = wmax(WH, WD);

  logic [WD-1:0] rem_r [WQ];
  logic [WD-1:0] dvs_r [WQ];
  logic [WQ-1:0] sh_r  [WQ+1];
  logic          ovf_r [WQ+1];

  logic [WR-1:0] hi_ext;
  logic [WR-1:0] dvs_ext;

  assign hi_ext  = WR'(dividend[WN-1:WQ]);
  assign dvs_ext = WR'(divisor);

  // first stage: upper part against divisor flags a quotient of 2^WQ or more
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_ext[WD-1:0];
      dvs_r[0] <= divisor;
      sh_r[0]  <= dividend[WQ-1:0];
      ovf_r[0] <= hi_ext >= dvs_ext;
    end
  end

  // one quotient bit per stage; dividend bits leave the top of sh as
  // quotient bits enter at the bottom
  for (genvar k = 1; k <= WQ; k++) begin : g_stage
    logic [WD:0] trial;
    logic [WD:0] diff;
    logic        ge;

    assign trial = {rem_r[k-1], sh_r[k-1][WQ-1]};
    assign diff  = trial - {1'b0, dvs_r[k-1]};
    assign ge    = trial >= {1'b0, dvs_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        sh_r[k]  <= {sh_r[k-1][WQ-2:0], ge};
        ovf_r[k] <= ovf_r[k-1];
      end
    end

    if (k < WQ) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[WD-1:0] : trial[WD-1:0];
          dvs_r[k] <= dvs_r[k-1];
        end
      end
    end
  end

  assign quo = sh_r[WQ];
  assign ovf = ovf_r[WQ];

endmodule

>>> rtl/truss_element_tangent_eval_core.sv
// Throughput: one request per cycle; a stalled result holds the whole pipeline.
// Latency is set by the two 36-stage square roots and the chain of two
// 65-stage dividers (axial force, then geometric term) behind them.
// Reset (synchronous, active low) empties the pipeline and loads the register
// defaults: geometric term on, minimum length 1, all else 0.
module truss_element_tangent_eval_core
  import tec_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_ref1_x,
  input  logic signed [COORD_W-1:0] in_ref1_y,
  input  logic signed [COORD_W-1:0] in_ref1_z,
  input  logic signed [COORD_W-1:0] in_ref2_x,
  input  logic signed [COORD_W-1:0] in_ref2_y,
  input  logic signed [COORD_W-1:0] in_ref2_z,
  input  logic signed [COORD_W-1:0] in_disp1_x,
  input  logic signed [COORD_W-1:0] in_disp1_y,
  input  logic signed [COORD_W-1:0] in_disp1_z,
  input  logic signed [COORD_W-1:0] in_disp2_x,
  input  logic signed [COORD_W-1:0] in_disp2_y,
  input  logic signed [COORD_W-1:0] in_disp2_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [OUT_W-1:0]   out_axial_force,
  output logic signed [OUT_W-1:0]   out_force_x,
  output logic signed [OUT_W-1:0]   out_force_y,
  output logic signed [OUT_W-1:0]   out_force_z,
  output logic signed [OUT_W-1:0]   out_stiff_xx,
  output logic signed [OUT_W-1:0]   out_stiff_yy,
  output logic signed [OUT_W-1:0]   out_stiff_zz,
  output logic signed [OUT_W-1:0]   out_stiff_xy,
  output logic signed [OUT_W-1:0]   out_stiff_xz,
  output logic signed [OUT_W-1:0]   out_stiff_yz,
  output logic                      out_degenerate,
  input  logic                      cfg_wr_en,
  input  cfg_idx_t                  cfg_index,
  input  logic [EA_W-1:0]           cfg_data
);

  localparam int LAT = 180;
  localparam int KWN = 57 + COORD_FRAC_BITS;
  localparam int GWN = OUT_W + COORD_FRAC_BITS;

  logic pipe_en;

  // configuration registers
  logic [EA_W-1:0]           ea_r;
  logic signed [31:0]        ts_r;
  logic                      geo_r;
  logic [31:0]               minlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ea_r     <= '0;
      ts_r     <= '0;
      geo_r    <= 1'b1;
      minlen_r <= 32'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_AXIAL_RIGIDITY:   ea_r     <= cfg_data;
        CFG_THERMAL_STRAIN:   ts_r     <= cfg_data[31:0];
        CFG_GEOMETRIC_ENABLE: geo_r    <= cfg_data[0];
        CFG_MIN_LENGTH:       minlen_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // valid bits alongside the data; the whole pipe moves unless the result stalls
  logic [LAT-1:0] vld_r;

  assign out_valid = vld_r[LAT-1];
  assign pipe_en   = !out_valid || out_ready;
  assign in_ready  = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // stage 1: node differences, magnitude and sign
  logic signed [COORD_W-1:0] r1 [3];
  logic signed [COORD_W-1:0] r2 [3];
  logic signed [COORD_W-1:0] u1 [3];
  logic signed [COORD_W-1:0] u2 [3];
  logic signed [33:0]        d0_s [3];
  logic signed [33:0]        dc_s [3];

  assign r1 = '{in_ref1_x, in_ref1_y, in_ref1_z};
  assign r2 = '{in_ref2_x, in_ref2_y, in_ref2_z};
  assign u1 = '{in_disp1_x, in_disp1_y, in_disp1_z};
  assign u2 = '{in_disp2_x, in_disp2_y, in_disp2_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d0_s[i] = 34'(r2[i]) - 34'(r1[i]);
      dc_s[i] = (34'(r2[i]) + 34'(u2[i])) - (34'(r1[i]) + 34'(u1[i]));
    end
  end

  logic [32:0] dm0_r [3];
  logic [33:0] dmc_r [3];
  logic [2:0]  dneg_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        dm0_r[i]  <= d0_s[i][33] ? 33'(-d0_s[i]) : 33'(d0_s[i]);
        dmc_r[i]  <= dc_s[i][33] ? 34'(-dc_s[i]) : 34'(dc_s[i]);
        dneg_r[i] <= dc_s[i][33];
      end
    end
  end

  // stage 2: squares; stage 3: sums of squares
  logic [65:0] sq0_r [3];
  logic [67:0] sqc_r [3];
  logic [67:0] s0_r;
  logic [69:0] sc_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        sq0_r[i] <= 66'(dm0_r[i]) * 66'(dm0_r[i]);
        sqc_r[i] <= 68'(dmc_r[i]) * 68'(dmc_r[i]);
      end
      s0_r <= 68'(sq0_r[0]) + 68'(sq0_r[1]) + 68'(sq0_r[2]);
      sc_r <= 70'(sqc_r[0]) + 70'(sqc_r[1]) + 70'(sqc_r[2]);
    end
  end

  // rest and current length
  logic [LEN_W-1:0] l0;
  logic [LEN_W-1:0] lc;

  tec_sqrt #(.WI(2*LEN_W)) u_sqrt_rest (
    .clk (clk), .en (pipe_en), .rad (72'(s0_r)), .root (l0)
  );

  tec_sqrt #(.WI(2*LEN_W)) u_sqrt_cur (
    .clk (clk), .en (pipe_en), .rad (72'(sc_r)), .root (lc)
  );

  // component magnitudes and signs wait for the lengths
  logic [33:0] dmc_l [3];
  logic [2:0]  dneg_l;

  tec_delay #(.W(105), .DEPTH(38)) u_dly_comp (
    .clk (clk), .en (pipe_en),
    .d   ({dneg_r, dmc_r[2], dmc_r[1], dmc_r[0]}),
    .q   ({dneg_l, dmc_l[2], dmc_l[1], dmc_l[0]})
  );

  // unit direction, Q1.30 magnitudes
  logic [DIR_W-1:0] q_dir [3];

  for (genvar i = 0; i < 3; i++) begin : g_dir
    tec_div #(.WN(64), .WD(LEN_W), .WQ(DIR_W)) u_div_dir (
      .clk      (clk),
      .en       (pipe_en),
      .dividend ({dmc_l[i], {DIR_FRAC{1'b0}}}),
      .divisor  (lc),
      .quo      (q_dir[i]),
      .ovf      ()
    );
  end

  // material stiffness EA / Lc
  logic [OUT_W-1:0] kq;
  logic             kovf;

  tec_div #(.WN(KWN), .WD(LEN_W), .WQ(OUT_W)) u_div_k (
    .clk      (clk),
    .en       (pipe_en),
    .dividend (KWN'(ea_r) << (COORD_FRAC_BITS + OUT_FRAC)),
    .divisor  (lc),
    .quo      (kq),
    .ovf      (kovf)
  );

  // axial force numerator: (Lc - L0) * 2^30 - thermal * L0, then times EA
  logic signed [36:0] dlt_r;
  logic signed [68:0] tl_r;
  logic [LEN_W-1:0]   l0_a_r, l0_b_r, l0_c_r, l0_d_r;
  logic               deg_a_r, deg_b_r, deg_c_r, deg_d_r;
  logic signed [69:0] num_s;
  logic [MAG_W-1:0]   nummag_r;
  logic               numneg_b_r, numneg_c_r, numneg_d_r;
  logic [73:0]        pplo_r, pphi_r;
  logic [107:0]       prod_r;

  assign num_s = (70'(dlt_r) <<< STRAIN_FRAC) - 70'(tl_r);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dlt_r      <= $signed({1'b0, lc}) - $signed({1'b0, l0});
      tl_r       <= 69'(ts_r) * 69'($signed({1'b0, l0}));
      l0_a_r     <= l0;
      deg_a_r    <= (l0 == '0) || (lc == '0) ||
                    (l0 < LEN_W'(minlen_r)) || (lc < LEN_W'(minlen_r));
      numneg_b_r <= num_s[69];
      nummag_r   <= num_s[69] ? MAG_W'(-num_s) : MAG_W'(num_s);
      l0_b_r     <= l0_a_r;
      deg_b_r    <= deg_a_r;
      pplo_r     <= 74'(nummag_r[33:0]) * 74'(ea_r);
      pphi_r     <= 74'(nummag_r[67:34]) * 74'(ea_r);
      numneg_c_r <= numneg_b_r;
      l0_c_r     <= l0_b_r;
      deg_c_r    <= deg_b_r;
      prod_r     <= 108'(pplo_r) + (108'(pphi_r) << 34);
      numneg_d_r <= numneg_c_r;
      l0_d_r     <= l0_c_r;
      deg_d_r    <= deg_c_r;
    end
  end

  logic [OUT_W-1:0] nq;
  logic             novf;

  tec_div #(.WN(108), .WD(LEN_W + NUM_SHIFT), .WQ(OUT_W)) u_div_force (
    .clk      (clk),
    .en       (pipe_en),
    .dividend (prod_r),
    .divisor  ({l0_d_r, {NUM_SHIFT{1'b0}}}),
    .quo      (nq),
    .ovf      (novf)
  );

  logic numneg_n;

  tec_delay #(.W(1), .DEPTH(65)) u_dly_nsign (
    .clk (clk), .en (pipe_en), .d (numneg_d_r), .q (numneg_n)
  );

  logic [LEN_W-1:0] lc_e;
  logic [2:0]       dneg_e;
  logic [DIR_W-1:0] q_e [3];

  tec_delay #(.W(LEN_W + 3), .DEPTH(70)) u_dly_len (
    .clk (clk), .en (pipe_en), .d ({dneg_l, lc}), .q ({dneg_e, lc_e})
  );

  tec_delay #(.W(3*DIR_W), .DEPTH(38)) u_dly_dir (
    .clk (clk), .en (pipe_en),
    .d   ({q_dir[2], q_dir[1], q_dir[0]}),
    .q   ({q_e[2], q_e[1], q_e[0]})
  );

  // saturated axial force and its magnitude
  q47_t             n_s;
  q47_t             nbits_r;
  logic [OUT_W-1:0] nmag_r;
  logic             nneg_r;

  assign n_s = sat_mag({3'b000, novf, nq}, numneg_n);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      nbits_r <= n_s;
      nmag_r  <= numneg_n ? (64'd0 - n_s) : n_s;
      nneg_r  <= numneg_n;
    end
  end

  // geometric term N / Lc
  logic [OUT_W-1:0] gq;
  logic             govf;

  tec_div #(.WN(GWN), .WD(LEN_W), .WQ(OUT_W)) u_div_geo (
    .clk      (clk),
    .en       (pipe_en),
    .dividend (GWN'(nmag_r) << COORD_FRAC_BITS),
    .divisor  (lc_e),
    .quo      (gq),
    .ovf      (govf)
  );

  // nodal force N * e, two partial products then sum
  logic [62:0] fpp0_r [3];
  logic [62:0] fpp1_r [3];
  logic [2:0]  fneg_r;
  q47_t        force_r [3];
  logic [94:0] fsum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fsum[i] = 95'(fpp0_r[i]) + (95'(fpp1_r[i]) << 32);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        fpp0_r[i]  <= 63'(nmag_r[31:0]) * 63'(q_e[i]);
        fpp1_r[i]  <= 63'(nmag_r[63:32]) * 63'(q_e[i]);
        fneg_r[i]  <= nneg_r ^ dneg_e[i];
        force_r[i] <= sat_mag(MAG_W'(fsum[i][94:DIR_FRAC]), fneg_r[i]);
      end
    end
  end

  // align stiffness, direction and signs with the geometric quotient
  logic [OUT_W-1:0] kq_g;
  logic             kovf_g;
  logic [DIR_W-1:0] q_g [3];
  logic [2:0]       dneg_g;
  logic             nneg_g;

  tec_delay #(.W(OUT_W + 1), .DEPTH(70)) u_dly_k (
    .clk (clk), .en (pipe_en), .d ({kovf, kq}), .q ({kovf_g, kq_g})
  );

  tec_delay #(.W(3*DIR_W + 4), .DEPTH(65)) u_dly_geo (
    .clk (clk), .en (pipe_en),
    .d   ({nneg_r, dneg_e, q_e[2], q_e[1], q_e[0]}),
    .q   ({nneg_g, dneg_g, q_g[2], q_g[1], q_g[0]})
  );

  // tangent block: (k - g) * e_i * e_j / 2^60, plus g on the diagonal
  q47_t             kbits_r, gbits_r;
  logic [61:0]      ee_r [6];
  logic [5:0]       sj_r;
  logic signed [65:0] cw_s;
  logic [64:0]      cmag_r;
  logic             cneg_r;
  logic [61:0]      ee_g_r [6];
  logic [5:0]       sj_g_r;
  q47_t             g_g_r, g_h_r, g_i_r, g_j_r;
  logic [63:0]      p00_r [6];
  logic [63:0]      p01_r [6];
  logic [62:0]      p10_r [6];
  logic [62:0]      p11_r [6];
  logic [5:0]       vneg_h_r, vneg_i_r, vneg_j_r;
  logic [95:0]      sa_r [6];
  logic [94:0]      sb_r [6];
  logic [127:0]     tot [6];
  logic [66:0]      vmag_r [6];

  assign cw_s = 66'(kbits_r) - 66'(gbits_r);

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      tot[j] = 128'(sa_r[j]) + (128'(sb_r[j]) << 33);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      kbits_r <= sat_mag({3'b000, kovf_g, kq_g}, 1'b0);
      gbits_r <= geo_r ? sat_mag({3'b000, govf, gq}, nneg_g) : '0;
      for (int j = 0; j < 6; j++) begin
        ee_r[j] <= 62'(q_g[PAIR_I[j]]) * 62'(q_g[PAIR_J[j]]);
        sj_r[j] <= dneg_g[PAIR_I[j]] ^ dneg_g[PAIR_J[j]];
      end
      cneg_r <= cw_s[65];
      cmag_r <= cw_s[65] ? 65'(-cw_s) : 65'(cw_s);
      ee_g_r <= ee_r;
      sj_g_r <= sj_r;
      g_g_r  <= gbits_r;
      for (int j = 0; j < 6; j++) begin
        p00_r[j] <= 64'(cmag_r[32:0]) * 64'(ee_g_r[j][30:0]);
        p01_r[j] <= 64'(cmag_r[32:0]) * 64'(ee_g_r[j][61:31]);
        p10_r[j] <= 63'(cmag_r[64:33]) * 63'(ee_g_r[j][30:0]);
        p11_r[j] <= 63'(cmag_r[64:33]) * 63'(ee_g_r[j][61:31]);
        vneg_h_r[j] <= cneg_r ^ sj_g_r[j];
        sa_r[j] <= 96'(p00_r[j]) + (96'(p01_r[j]) << 31);
        sb_r[j] <= 95'(p10_r[j]) + (95'(p11_r[j]) << 31);
        vmag_r[j] <= tot[j][126:2*DIR_FRAC];
      end
      g_h_r    <= g_g_r;
      vneg_i_r <= vneg_h_r;
      g_i_r    <= g_h_r;
      vneg_j_r <= vneg_i_r;
      g_j_r    <= g_i_r;
    end
  end

  // late side data for the output stage
  logic deg_o;
  q47_t nbits_o;
  q47_t force_o [3];

  tec_delay #(.W(1), .DEPTH(136)) u_dly_deg (
    .clk (clk), .en (pipe_en), .d (deg_d_r), .q (deg_o)
  );

  tec_delay #(.W(OUT_W), .DEPTH(70)) u_dly_n (
    .clk (clk), .en (pipe_en), .d (nbits_r), .q (nbits_o)
  );

  tec_delay #(.W(3*OUT_W), .DEPTH(68)) u_dly_f (
    .clk (clk), .en (pipe_en),
    .d   ({force_r[2], force_r[1], force_r[0]}),
    .q   ({force_o[2], force_o[1], force_o[0]})
  );

  // output register
  logic signed [68:0] vs [6];
  q47_t               stiff_nxt [6];
  q47_t               axial_r;
  q47_t               fout_r [3];
  q47_t               stiff_r [6];
  logic               deg_r;

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      vs[j] = vneg_j_r[j] ? -$signed(69'(vmag_r[j])) : $signed(69'(vmag_r[j]));
      if (j < 3) begin
        vs[j] = vs[j] + 69'(g_j_r);
      end
      stiff_nxt[j] = sat_s(vs[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      deg_r   <= deg_o;
      axial_r <= deg_o ? '0 : nbits_o;
      for (int i = 0; i < 3; i++) begin
        fout_r[i] <= deg_o ? '0 : force_o[i];
      end
      for (int j = 0; j < 6; j++) begin
        stiff_r[j] <= deg_o ? '0 : stiff_nxt[j];
      end
    end
  end

  assign out_axial_force = axial_r;
  assign out_force_x     = fout_r[0];
  assign out_force_y     = fout_r[1];
  assign out_force_z     = fout_r[2];
  assign out_stiff_xx    = stiff_r[0];
  assign out_stiff_yy    = stiff_r[1];
  assign out_stiff_zz    = stiff_r[2];
  assign out_stiff_xy    = stiff_r[3];
  assign out_stiff_xz    = stiff_r[4];
  assign out_stiff_yz    = stiff_r[5];
  assign out_degenerate  = deg_r;

`ifndef ASSERT_OFF
  // a degenerate element gives zero axial force, nodal forces and xx, xy, yz stiffness
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_axial_force == '0 && out_force_x == '0 &&
      out_force_y == '0 && out_force_z == '0 && out_stiff_xx == '0 &&
      out_stiff_xy == '0 && out_stiff_yz == '0)
    else $error("degenerate result not cleared");

  // a stalled result is not dropped by the pipeline
  a_stall_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result lost");

  // reset empties the valid chain
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
